@@ rtl/hkmr_pkg.sv @@
// ----------------------------------------------------------------------------
// hkmr_pkg
// Shared types and constants of the keyboard and mouse report tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hkmr_pkg;

   localparam int KEY_SLOTS_DEFAULT = 6;
   localparam int REPORT_KEYS       = 6;
   localparam int KEYS_WIDTH        = 8 * REPORT_KEYS;

   localparam logic [7:0] MOD_FIRST = 8'hE0;
   localparam logic [7:0] MOD_LAST  = 8'hE7;

   localparam logic [7:0] KBD_ID_RESET   = 8'd1;
   localparam logic [7:0] MOUSE_ID_RESET = 8'd2;

   localparam logic [7:0] CSR_KBD_ID   = 8'd0;
   localparam logic [7:0] CSR_MOUSE_ID = 8'd1;

   typedef enum logic [2:0] {
      OP_KEYDOWN     = 3'd0,
      OP_KEYUP       = 3'd1,
      OP_KEYRESET    = 3'd2,
      OP_KBDLOAD     = 3'd3,
      OP_MOUSEUPDATE = 3'd4,
      OP_MOUSERESET  = 3'd5,
      OP_MOUSELOAD   = 3'd6,
      OP_GETSTATE    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_KEYBOARD = 2'd0,
      KIND_MOUSE    = 2'd1,
      KIND_STATE    = 2'd2
   } kind_type;

   typedef struct packed {
      logic                  update;
      op_type                op;
      logic [7:0]            usage;
      logic [7:0]            load_modifiers;
      logic [KEYS_WIDTH-1:0] load_keys;
   } key_cmd_type;

   typedef struct packed {
      logic               update;
      op_type             op;
      logic [7:0]         buttons_set;
      logic [7:0]         buttons_clear;
      logic [7:0]         load_buttons;
      logic signed [15:0] delta_x;
      logic signed [15:0] delta_y;
      logic signed [7:0]  wheel;
      logic signed [7:0]  hwheel;
   } mouse_cmd_type;

   typedef struct packed {
      logic [7:0]         buttons;
      logic signed [15:0] dx;
      logic signed [15:0] dy;
      logic signed [7:0]  wheel;
      logic signed [7:0]  hwheel;
   } mouse_report_type;

endpackage

`default_nettype wire

@@ rtl/hkmr_key_state.sv @@
// ----------------------------------------------------------------------------
// hkmr_key_state
// Boot keyboard state: modifier byte and key slots with one-pass update.
// ----------------------------------------------------------------------------
`default_nettype none

module hkmr_key_state
   import hkmr_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire key_cmd_type           cmd,
   output logic      [7:0]            modifiers_next,
   output logic      [KEYS_WIDTH-1:0] keys_next
);

   logic [7:0]           modifiers_ff;
   logic [7:0]           modifiers_in;
   logic [7:0]           slots_ff [KEY_SLOTS];
   logic [7:0]           slots_in [KEY_SLOTS];
   logic [7:0]           load_slot [KEY_SLOTS];
   logic [KEY_SLOTS-1:0] first_free;
   logic [KEY_SLOTS-1:0] first_hit;
   logic                 any_hit;
   logic                 is_mod;
   logic [2:0]           mod_bit;

   genvar g;
   generate
      for (g = 0; g < KEY_SLOTS; g++) begin : g_load
         if (g < REPORT_KEYS) begin : g_src
            assign load_slot[g] = cmd.load_keys[8*g +: 8];
         end else begin : g_zero
            assign load_slot[g] = 8'd0;
         end
      end
      for (g = 0; g < REPORT_KEYS; g++) begin : g_pack
         if (g < KEY_SLOTS) begin : g_src
            assign keys_next[8*g +: 8] = slots_in[g];
         end else begin : g_zero
            assign keys_next[8*g +: 8] = 8'd0;
         end
      end
   endgenerate

   assign is_mod  = (cmd.usage >= MOD_FIRST) && (cmd.usage <= MOD_LAST);
   assign mod_bit = cmd.usage[2:0];

   always_comb begin
      logic seen_free;
      logic seen_hit;
      seen_free = 1'b0;
      seen_hit  = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         first_free[i] = (slots_ff[i] == 8'd0) && !seen_free;
         first_hit[i]  = (slots_ff[i] == cmd.usage) && !seen_hit;
         seen_free     = seen_free || (slots_ff[i] == 8'd0);
         seen_hit      = seen_hit || (slots_ff[i] == cmd.usage);
      end
      any_hit = seen_hit;
   end

   always_comb begin
      modifiers_in = modifiers_ff;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         slots_in[i] = slots_ff[i];
      end
      unique case (cmd.op) inside
         OP_KEYDOWN: begin
            if (cmd.usage != 8'd0) begin
               if (is_mod) begin
                  modifiers_in[mod_bit] = 1'b1;
               end else if (!any_hit) begin
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (first_free[i]) begin
                        slots_in[i] = cmd.usage;
                     end
                  end
               end
            end
         end
         OP_KEYUP: begin
            if (cmd.usage != 8'd0) begin
               if (is_mod) begin
                  modifiers_in[mod_bit] = 1'b0;
               end else begin
                  for (int i = 0; i < KEY_SLOTS; i++) begin
                     if (first_hit[i]) begin
                        slots_in[i] = 8'd0;
                     end
                  end
               end
            end
         end
         OP_KEYRESET: begin
            modifiers_in = 8'd0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               slots_in[i] = 8'd0;
            end
         end
         OP_KBDLOAD: begin
            modifiers_in = cmd.load_modifiers;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               slots_in[i] = load_slot[i];
            end
         end
         OP_MOUSEUPDATE, OP_MOUSERESET, OP_MOUSELOAD, OP_GETSTATE: begin
         end
      endcase
   end

   assign modifiers_next = modifiers_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         modifiers_ff <= 8'd0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= 8'd0;
         end
      end else if (cmd.update) begin
         modifiers_ff <= modifiers_in;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= slots_in[i];
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/hkmr_mouse_state.sv @@
// ----------------------------------------------------------------------------
// hkmr_mouse_state
// Mouse button state and the motion fields of a mouse report.
// ----------------------------------------------------------------------------
`default_nettype none

module hkmr_mouse_state
   import hkmr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire mouse_cmd_type cmd,
   output mouse_report_type   report
);

   logic [7:0] buttons_ff;
   logic [7:0] buttons_in;

   always_comb begin
      buttons_in    = buttons_ff;
      report.dx     = cmd.delta_x;
      report.dy     = cmd.delta_y;
      report.wheel  = cmd.wheel;
      report.hwheel = cmd.hwheel;
      unique case (cmd.op) inside
         OP_MOUSEUPDATE: begin
            buttons_in = (buttons_ff & ~cmd.buttons_clear) | cmd.buttons_set;
         end
         OP_MOUSERESET: begin
            buttons_in    = 8'd0;
            report.dx     = 16'sd0;
            report.dy     = 16'sd0;
            report.wheel  = 8'sd0;
            report.hwheel = 8'sd0;
         end
         OP_MOUSELOAD: begin
            buttons_in = cmd.load_buttons;
         end
         OP_KEYDOWN, OP_KEYUP, OP_KEYRESET, OP_KBDLOAD, OP_GETSTATE: begin
         end
      endcase
      report.buttons = buttons_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buttons_ff <= 8'd0;
      end else if (cmd.update) begin
         buttons_ff <= buttons_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/hid_keyboard_mouse_report_tracker.sv @@
// ----------------------------------------------------------------------------
// hid_keyboard_mouse_report_tracker
// Keyboard (boot, six-key rollover) and mouse report tracker, top level.
// ----------------------------------------------------------------------------
// Takes one item per clock and gives exactly one report per item. An item
// goes into an input register, is applied to the keyboard and mouse state by
// slot comparators and a first-free/first-match pick, and its report lands
// in the output register, which drives rsp_valid; one item per cycle is
// sustained while rsp_stall stays low. A stalled output holds one report and
// one more item waits in the input register. Report IDs are written through
// the csr port, which is always ready; write it only while no item is in
// flight.
`default_nettype none

module hid_keyboard_mouse_report_tracker
   import hkmr_pkg::*;
#(
   parameter int KEY_SLOTS = KEY_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [2:0]            req_operation,
   input  wire logic [7:0]            req_key_usage,
   input  wire logic [7:0]            req_load_modifiers,
   input  wire logic [KEYS_WIDTH-1:0] req_load_keys,
   input  wire logic [7:0]            req_buttons_set,
   input  wire logic [7:0]            req_buttons_clear,
   input  wire logic [7:0]            req_load_buttons,
   input  wire logic signed [15:0]    req_delta_x,
   input  wire logic signed [15:0]    req_delta_y,
   input  wire logic signed [7:0]     req_wheel,
   input  wire logic signed [7:0]     req_hwheel,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [1:0]                 rsp_report_kind,
   output logic [7:0]                 rsp_report_id,
   output logic [7:0]                 rsp_modifiers_out,
   output logic [KEYS_WIDTH-1:0]      rsp_keys_out,
   output logic [7:0]                 rsp_buttons_out,
   output logic signed [15:0]         rsp_dx_out,
   output logic signed [15:0]         rsp_dy_out,
   output logic signed [7:0]          rsp_wheel_out,
   output logic signed [7:0]          rsp_hwheel_out,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [7:0]            csr_index,
   input  wire logic [7:0]            csr_wdata
);

   // config
   logic [7:0] kbd_id_ff;
   logic [7:0] mouse_id_ff;

   // input register
   logic                  s1_valid_ff;
   op_type                s1_op_ff;
   logic [7:0]            s1_usage_ff;
   logic [7:0]            s1_load_modifiers_ff;
   logic [KEYS_WIDTH-1:0] s1_load_keys_ff;
   logic [7:0]            s1_buttons_set_ff;
   logic [7:0]            s1_buttons_clear_ff;
   logic [7:0]            s1_load_buttons_ff;
   logic signed [15:0]    s1_delta_x_ff;
   logic signed [15:0]    s1_delta_y_ff;
   logic signed [7:0]     s1_wheel_ff;
   logic signed [7:0]     s1_hwheel_ff;

   // result register
   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff;
   kind_type              rsp_kind_in;
   logic [7:0]            rsp_id_ff;
   logic [7:0]            rsp_id_in;
   logic [7:0]            rsp_mods_ff;
   logic [7:0]            rsp_mods_in;
   logic [KEYS_WIDTH-1:0] rsp_keys_ff;
   logic [KEYS_WIDTH-1:0] rsp_keys_in;
   logic [7:0]            rsp_buttons_ff;
   logic [7:0]            rsp_buttons_in;
   logic signed [15:0]    rsp_dx_ff;
   logic signed [15:0]    rsp_dx_in;
   logic signed [15:0]    rsp_dy_ff;
   logic signed [15:0]    rsp_dy_in;
   logic signed [7:0]     rsp_wheel_ff;
   logic signed [7:0]     rsp_wheel_in;
   logic signed [7:0]     rsp_hwheel_ff;
   logic signed [7:0]     rsp_hwheel_in;

   logic                  out_free;
   logic                  advance;
   logic                  req_take;
   key_cmd_type           key_cmd;
   mouse_cmd_type         mouse_cmd;
   logic [7:0]            modifiers_next;
   logic [KEYS_WIDTH-1:0] keys_next;
   mouse_report_type      mouse_report;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kbd_id_ff   <= KBD_ID_RESET;
         mouse_id_ff <= MOUSE_ID_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_KBD_ID:   kbd_id_ff   <= csr_wdata;
            CSR_MOUSE_ID: mouse_id_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff             <= op_type'(req_operation);
         s1_usage_ff          <= req_key_usage;
         s1_load_modifiers_ff <= req_load_modifiers;
         s1_load_keys_ff      <= req_load_keys;
         s1_buttons_set_ff    <= req_buttons_set;
         s1_buttons_clear_ff  <= req_buttons_clear;
         s1_load_buttons_ff   <= req_load_buttons;
         s1_delta_x_ff        <= req_delta_x;
         s1_delta_y_ff        <= req_delta_y;
         s1_wheel_ff          <= req_wheel;
         s1_hwheel_ff         <= req_hwheel;
      end
   end

   assign key_cmd.update         = advance;
   assign key_cmd.op             = s1_op_ff;
   assign key_cmd.usage          = s1_usage_ff;
   assign key_cmd.load_modifiers = s1_load_modifiers_ff;
   assign key_cmd.load_keys      = s1_load_keys_ff;

   assign mouse_cmd.update        = advance;
   assign mouse_cmd.op            = s1_op_ff;
   assign mouse_cmd.buttons_set   = s1_buttons_set_ff;
   assign mouse_cmd.buttons_clear = s1_buttons_clear_ff;
   assign mouse_cmd.load_buttons  = s1_load_buttons_ff;
   assign mouse_cmd.delta_x       = s1_delta_x_ff;
   assign mouse_cmd.delta_y       = s1_delta_y_ff;
   assign mouse_cmd.wheel         = s1_wheel_ff;
   assign mouse_cmd.hwheel        = s1_hwheel_ff;

   hkmr_key_state #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_key_state (
      .clock          (clock),
      .reset          (reset),
      .cmd            (key_cmd),
      .modifiers_next (modifiers_next),
      .keys_next      (keys_next)
   );

   hkmr_mouse_state u_mouse_state (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mouse_cmd),
      .report (mouse_report)
   );

   always_comb begin
      rsp_kind_in    = KIND_STATE;
      rsp_id_in      = 8'd0;
      rsp_mods_in    = 8'd0;
      rsp_keys_in    = '0;
      rsp_buttons_in = 8'd0;
      rsp_dx_in      = 16'sd0;
      rsp_dy_in      = 16'sd0;
      rsp_wheel_in   = 8'sd0;
      rsp_hwheel_in  = 8'sd0;
      unique case (s1_op_ff) inside
         OP_KEYDOWN, OP_KEYUP, OP_KEYRESET, OP_KBDLOAD: begin
            rsp_kind_in = KIND_KEYBOARD;
            rsp_id_in   = kbd_id_ff;
            rsp_mods_in = modifiers_next;
            rsp_keys_in = keys_next;
         end
         OP_MOUSEUPDATE, OP_MOUSERESET, OP_MOUSELOAD: begin
            rsp_kind_in    = KIND_MOUSE;
            rsp_id_in      = mouse_id_ff;
            rsp_buttons_in = mouse_report.buttons;
            rsp_dx_in      = mouse_report.dx;
            rsp_dy_in      = mouse_report.dy;
            rsp_wheel_in   = mouse_report.wheel;
            rsp_hwheel_in  = mouse_report.hwheel;
         end
         OP_GETSTATE: begin
            rsp_mods_in    = modifiers_next;
            rsp_keys_in    = keys_next;
            rsp_buttons_in = mouse_report.buttons;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_id_ff      <= rsp_id_in;
         rsp_mods_ff    <= rsp_mods_in;
         rsp_keys_ff    <= rsp_keys_in;
         rsp_buttons_ff <= rsp_buttons_in;
         rsp_dx_ff      <= rsp_dx_in;
         rsp_dy_ff      <= rsp_dy_in;
         rsp_wheel_ff   <= rsp_wheel_in;
         rsp_hwheel_ff  <= rsp_hwheel_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_report_kind   = rsp_kind_ff;
   assign rsp_report_id     = rsp_id_ff;
   assign rsp_modifiers_out = rsp_mods_ff;
   assign rsp_keys_out      = rsp_keys_ff;
   assign rsp_buttons_out   = rsp_buttons_ff;
   assign rsp_dx_out        = rsp_dx_ff;
   assign rsp_dy_out        = rsp_dy_ff;
   assign rsp_wheel_out     = rsp_wheel_ff;
   assign rsp_hwheel_out    = rsp_hwheel_ff;

endmodule

`default_nettype wire
